// ===== hw/rtl/box_blur_9x9_rgb_unit_macros.svh =====
// Assertion macros for the 9x9 box blur unit.
// Used by the top level only; the assertion forms expect clk and rst_n in scope.
`ifndef BOX_BLUR_9X9_RGB_UNIT_MACROS_SVH
`define BOX_BLUR_9X9_RGB_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BB9_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BB9_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BB9_ASSERT_NOW(lbl, ante, cons, msg)
`define BB9_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/bb9_pkg.sv =====
// Package for the 9x9 box blur unit: field widths, register indexes and the
// transaction and pipeline types shared by the modules, interfaces and testbench. No dependencies.
package bb9_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_CH    = 3;
  localparam int COORD_W   = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  // Channel 0 is red, 1 is green, 2 is blue.
  typedef pix_t [NUM_CH-1:0] rgb_t;

  typedef struct packed {
    logic frame_start;
    pix_t red_in;
    pix_t green_in;
    pix_t blue_in;
  } in_item_t;

  typedef struct packed {
    pix_t               red_out;
    pix_t               green_out;
    pix_t               blue_out;
    logic [COORD_W-1:0] centre_row;
    logic [COORD_W-1:0] centre_col;
  } out_item_t;

  // Position status that travels with a pixel down the pipeline.
  typedef struct packed {
    logic               row_ok;
    logic               col_ok;
    logic [COORD_W-1:0] centre_row;
    logic [COORD_W-1:0] centre_col;
  } pos_info_t;

endpackage

// ===== hw/rtl/bb9_if.sv =====
// Stream interfaces for the 9x9 box blur unit: pixel input and blurred result.
// Depends on bb9_pkg for the payload types.
interface bb9_in_if import bb9_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bb9_out_if import bb9_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bb9_position.sv =====
// Raster position tracking for the 9x9 box blur unit: column, row and line slot
// counters, geometry clamping and border flags. Depends on bb9_pkg.
module bb9_position import bb9_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int RADIUS     = 4,
  localparam int LINES  = 2 * RADIUS,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int ROW_W  = $clog2(MAX_HEIGHT),
  localparam int SLOT_W = $clog2(LINES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic              frame_start,
  input  logic [CFG_W-1:0]  width_cfg,
  input  logic [CFG_W-1:0]  height_cfg,
  output logic [COL_W-1:0]  cur_col,
  output logic [SLOT_W-1:0] cur_slot,
  output pos_info_t         cur_info
);

  localparam int WD_W = $clog2(MAX_WIDTH + 1);
  localparam int HT_W = $clog2(MAX_HEIGHT + 1);

  logic [COL_W-1:0]  col_r, col_nxt, c0;
  logic [ROW_W-1:0]  row_r, row_nxt, cur_row;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [WD_W-1:0]   w;
  logic [HT_W-1:0]   h;

  // A width or height of zero acts as one; oversized values act as the maximum.
  always_comb begin
    if (width_cfg == '0) begin
      w = WD_W'(1);
    end else if (int'(width_cfg) > MAX_WIDTH) begin
      w = WD_W'(MAX_WIDTH);
    end else begin
      w = WD_W'(width_cfg);
    end
    if (height_cfg == '0) begin
      h = HT_W'(1);
    end else if (int'(height_cfg) > MAX_HEIGHT) begin
      h = HT_W'(MAX_HEIGHT);
    end else begin
      h = HT_W'(height_cfg);
    end
  end

  always_comb begin
    c0       = frame_start ? '0 : col_r;
    cur_row  = frame_start ? '0 : row_r;
    cur_slot = frame_start ? '0 : slot_r;
    // A column left beyond a shrunk width sits on the last column.
    cur_col  = (WD_W'(c0) >= w) ? COL_W'(w - WD_W'(1)) : c0;

    cur_info.row_ok     = (cur_row >= ROW_W'(LINES));
    cur_info.col_ok     = (cur_col >= COL_W'(LINES));
    cur_info.centre_row = COORD_W'(cur_row - ROW_W'(RADIUS));
    cur_info.centre_col = COORD_W'(cur_col - COL_W'(RADIUS));

    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (acc) begin
      if (WD_W'(cur_col) + WD_W'(1) >= w) begin
        col_nxt = '0;
        if (HT_W'(cur_row) + HT_W'(1) >= h) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = cur_row + 1'b1;
          slot_nxt = (cur_slot == SLOT_W'(LINES - 1)) ? '0 : cur_slot + 1'b1;
        end
      end else begin
        col_nxt  = cur_col + 1'b1;
        row_nxt  = cur_row;
        slot_nxt = cur_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

// ===== hw/rtl/bb9_line_store.sv =====
// Line store for the 9x9 box blur unit: one RAM bank per stored line, all
// banks read at the pixel's column, one bank written. Depends on bb9_pkg.
module bb9_line_store import bb9_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int RADIUS    = 4,
  localparam int LINES  = 2 * RADIUS,
  localparam int ADDR_W = $clog2(MAX_WIDTH),
  localparam int SLOT_W = $clog2(LINES)
) (
  input  logic                   clk,
  input  logic                   acc,
  input  logic [SLOT_W-1:0]      wr_slot,
  input  logic [ADDR_W-1:0]      addr,
  input  rgb_t                   wdata,
  output rgb_t [LINES-1:0]       rd_data
);

  for (genvar b = 0; b < LINES; b++) begin : g_bank
    rgb_t mem [MAX_WIDTH];
    rgb_t rd_r;

    // Read returns the old entry when the same entry is written in that cycle.
    always_ff @(posedge clk) begin
      if (acc) begin
        if (wr_slot == SLOT_W'(b)) begin
          mem[addr] <= wdata;
        end
        rd_r <= mem[addr];
      end
    end

    assign rd_data[b] = rd_r;
  end

endmodule

// ===== hw/rtl/bb9_window.sv =====
// Column sums and sliding window sums for the 9x9 box blur unit.
// Keeps the column window and a running total per channel. Depends on bb9_pkg.
module bb9_window import bb9_pkg::*; #(
  parameter int RADIUS = 4,
  localparam int LINES    = 2 * RADIUS,
  localparam int SPAN     = LINES + 1,
  localparam int AREA     = SPAN * SPAN,
  localparam int PIX_MAX  = (1 << PIX_W) - 1,
  localparam int COLSUM_W = $clog2(SPAN * PIX_MAX + 1),
  localparam int SUM_W    = $clog2(AREA * PIX_MAX + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         s1_valid,
  input  pos_info_t                    s1_info,
  input  rgb_t                         s1_pix,
  input  rgb_t [LINES-1:0]             rd_data,
  output logic                         s3_valid,
  output pos_info_t                    s3_info,
  output logic [NUM_CH-1:0][SUM_W-1:0] s3_sum
);

  logic                            s2_valid_r, s3_valid_r;
  pos_info_t                       s2_info_r, s3_info_r;
  logic [NUM_CH-1:0][COLSUM_W-1:0] col_sum_nxt, col_sum_r;
  logic [NUM_CH-1:0][COLSUM_W-1:0] win_r [SPAN];
  logic [NUM_CH-1:0][SUM_W-1:0]    win_sum_r, win_sum_nxt;

  // Column sum: the new pixel plus the stored lines above it, zero in early rows.
  always_comb begin
    logic [COLSUM_W-1:0] acc_v;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc_v = COLSUM_W'(s1_pix[ch]);
      for (int k = 0; k < LINES; k++) begin
        acc_v = acc_v + COLSUM_W'(rd_data[k][ch]);
      end
      col_sum_nxt[ch] = s1_info.row_ok ? acc_v : '0;
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      win_sum_nxt[ch] = win_sum_r[ch] - SUM_W'(win_r[0][ch]) + SUM_W'(col_sum_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      win_sum_r  <= '0;
      for (int k = 0; k < SPAN; k++) begin
        win_r[k] <= '0;
      end
    end else if (adv) begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
      if (s2_valid_r) begin
        for (int k = 0; k < SPAN - 1; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[SPAN-1] <= col_sum_r;
        win_sum_r     <= win_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_info_r <= s1_info;
      col_sum_r <= col_sum_nxt;
      s3_info_r <= s2_info_r;
    end
  end

  // The running total only moves with a valid pixel, so it is the pixel's sum.
  assign s3_valid = s3_valid_r;
  assign s3_info  = s3_info_r;
  assign s3_sum   = win_sum_r;

endmodule

// ===== hw/rtl/bb9_divide.sv =====
// Division of the window sums by the window area for the 9x9 box blur unit,
// as a multiply by a rounded-up reciprocal and a shift. Depends on bb9_pkg.
module bb9_divide import bb9_pkg::*; #(
  parameter int RADIUS = 4,
  localparam int SPAN    = 2 * RADIUS + 1,
  localparam int AREA    = SPAN * SPAN,
  localparam int PIX_MAX = (1 << PIX_W) - 1,
  localparam int SUM_W   = $clog2(AREA * PIX_MAX + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         s3_valid,
  input  pos_info_t                    s3_info,
  input  logic [NUM_CH-1:0][SUM_W-1:0] s3_sum,
  output logic                         s4_valid,
  output pos_info_t                    s4_info,
  output rgb_t                         quotient
);

  // With the shift at SUM_W plus the bits of AREA, the rounding error of the
  // reciprocal stays below one for every sum, so the quotient is exact.
  localparam int DIV_K   = SUM_W + $clog2(AREA);
  localparam int RECIP   = ((1 << DIV_K) + AREA - 1) / AREA;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;

  logic                          s4_valid_r;
  pos_info_t                     s4_info_r;
  logic [NUM_CH-1:0][PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_info_r <= s3_info;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod_r[ch] <= PROD_W'(s3_sum[ch]) * PROD_W'(RECIP);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      quotient[ch] = PIX_W'(prod_r[ch] >> DIV_K);
    end
  end

  assign s4_valid = s4_valid_r;
  assign s4_info  = s4_info_r;

endmodule

// ===== hw/rtl/box_blur_9x9_rgb_unit.sv =====
// Top level of the 9x9 box blur unit: configuration registers, pipeline control,
// result register. Depends on bb9_pkg, bb9_if, the bb9 submodules and the macros.
//
// Usage:
// - in_s carries RGB pixels in raster order; frame_start marks the first pixel
//   of a frame. out_s carries the 9x9 average per channel with the row and
//   column of the window centre. Pixels whose window would leave the image
//   produce no result transaction.
// - cfg_we, cfg_index and cfg_wdata set image_width (index 0) and image_height
//   (index 1); write them only while the unit is idle.
// - Throughput is one pixel per clock while out_s is not stalled. Between the edge
//   that accepts a pixel and its result on out_s lie the registers of the line
//   store read, the column sum, the window update, the multiply and the output.
// - When the receiver holds out_s.ready low with a result waiting, the whole
//   pipeline freezes and in_s.ready drops in the same cycle; nothing is lost.
// - Reset clears the position counters and the column window and sets both
//   dimensions to 800. The line store is not cleared; its entries are written
//   by the first lines of a frame before they are read, so no clearing pass.
`include "box_blur_9x9_rgb_unit_macros.svh"
module box_blur_9x9_rgb_unit import bb9_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int RADIUS     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bb9_in_if.sink               in_s,
  bb9_out_if.source            out_s,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int LINES   = 2 * RADIUS;
  localparam int SPAN    = LINES + 1;
  localparam int AREA    = SPAN * SPAN;
  localparam int PIX_MAX = (1 << PIX_W) - 1;
  localparam int SUM_W   = $clog2(AREA * PIX_MAX + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int SLOT_W  = $clog2(LINES);

  logic [CFG_W-1:0] width_r, height_r;

  logic adv, acc;

  logic [COL_W-1:0]  cur_col;
  logic [SLOT_W-1:0] cur_slot;
  pos_info_t         cur_info;
  rgb_t              in_pix;
  rgb_t [LINES-1:0]  rd_data;

  logic      s1_valid_r;
  pos_info_t s1_info_r;
  rgb_t      s1_pix_r;

  logic                         s3_valid, s4_valid;
  pos_info_t                    s3_info, s4_info;
  logic [NUM_CH-1:0][SUM_W-1:0] s3_sum;
  rgb_t                         quotient;

  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Every stage moves together unless a result is waiting on a stalled receiver.
  assign adv        = !out_valid_r || out_s.ready;
  assign in_s.ready = adv;
  assign acc        = in_s.valid && adv;

  assign in_pix[0] = in_s.payload.red_in;
  assign in_pix[1] = in_s.payload.green_in;
  assign in_pix[2] = in_s.payload.blue_in;

  bb9_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .RADIUS     (RADIUS)
  ) u_position (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .frame_start (in_s.payload.frame_start),
    .width_cfg   (width_r),
    .height_cfg  (height_r),
    .cur_col     (cur_col),
    .cur_slot    (cur_slot),
    .cur_info    (cur_info)
  );

  bb9_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_line_store (
    .clk     (clk),
    .acc     (acc),
    .wr_slot (cur_slot),
    .addr    (cur_col),
    .wdata   (in_pix),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_info_r <= cur_info;
      s1_pix_r  <= in_pix;
    end
  end

  bb9_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s1_valid (s1_valid_r),
    .s1_info  (s1_info_r),
    .s1_pix   (s1_pix_r),
    .rd_data  (rd_data),
    .s3_valid (s3_valid),
    .s3_info  (s3_info),
    .s3_sum   (s3_sum)
  );

  bb9_divide #(
    .RADIUS (RADIUS)
  ) u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s3_valid (s3_valid),
    .s3_info  (s3_info),
    .s3_sum   (s3_sum),
    .s4_valid (s4_valid),
    .s4_info  (s4_info),
    .quotient (quotient)
  );

  always_comb begin
    out_item_nxt.red_out    = quotient[0];
    out_item_nxt.green_out  = quotient[1];
    out_item_nxt.blue_out   = quotient[2];
    out_item_nxt.centre_row = s4_info.centre_row;
    out_item_nxt.centre_col = s4_info.centre_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_valid && s4_info.row_ok && s4_info.col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_s.valid   = out_valid_r;
  assign out_s.payload = out_item_r;

  `BB9_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(s1_valid_r) && $stable(s4_valid), "pipeline moved during an output stall")
  `BB9_ASSERT_NOW(a_result_from_pipe, $rose(out_valid_r), $past(s4_valid && adv), "result appeared without a pixel in the last stage")
  `BB9_ASSERT_NEXT(a_frame_start_border, acc && in_s.payload.frame_start, s1_valid_r && !s1_info_r.row_ok && !s1_info_r.col_ok, "first pixel of a frame not marked as border")

endmodule

// ===== sim/box_blur_9x9_rgb_unit_tb.sv =====
// Self-checking testbench for box_blur_9x9_rgb_unit: streams RGB frames of many
// geometries and checks every blurred pixel against a line-buffer predictor.
// Depends on bb9_pkg, bb9_if and box_blur_9x9_rgb_unit from the RTL.
`timescale 1ns / 1ps

package box_blur_tb_pkg;
  import bb9_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 1024;
  localparam int BLUR_RADIUS = 4;
  localparam int SPAN        = 2 * BLUR_RADIUS + 1;
  localparam int LINES       = 2 * BLUR_RADIUS;
  localparam int AREA        = SPAN * SPAN;
  localparam int MAX_REPORTS = 40;

  class blur_scoreboard;
    logic [23:0]  line_mem [LINES*MAX_W];
    int unsigned  col_win [SPAN][3];
    int unsigned  row_pos;
    int unsigned  col_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    out_item_t    blurred_q [$];
    int unsigned  errors;
    int unsigned  pixels;
    int unsigned  predicted;
    int unsigned  results;

    function new();
      foreach (col_win[k, ch]) col_win[k][ch] = 0;
      row_pos    = 0;
      col_pos    = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
      pixels     = 0;
      predicted  = 0;
      results    = 0;
    endfunction

    // Dimension as the block uses it: zero acts as one, oversize saturates.
    static function int unsigned eff_dim(int unsigned v, int unsigned maxv);
      if (v > maxv) return maxv;
      if (v == 0) return 1;
      return v;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = v;
        CFG_IMAGE_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function void add_pixel(in_item_t px);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned s;
      int unsigned col_sum [3];
      logic [23:0] pix;
      logic [23:0] old;
      out_item_t   blurred;
      w = eff_dim(width_reg, MAX_W);
      h = eff_dim(height_reg, MAX_H);
      pixels++;
      if (px.frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = (col_pos >= w) ? w - 1 : col_pos;
      pix = {px.blue_in, px.green_in, px.red_in};
      for (int ch = 0; ch < 3; ch++) col_sum[ch] = 0;
      // Column sums exist only once the line store holds a full set of lines.
      if (r >= LINES) begin
        for (int ch = 0; ch < 3; ch++) col_sum[ch] = pix[8*ch +: 8];
        for (int k = 1; k <= LINES; k++) begin
          old = line_mem[((r - k) % LINES) * MAX_W + c];
          for (int ch = 0; ch < 3; ch++) col_sum[ch] += old[8*ch +: 8];
        end
      end
      for (int k = 0; k < SPAN - 1; k++)
        for (int ch = 0; ch < 3; ch++) col_win[k][ch] = col_win[k+1][ch];
      for (int ch = 0; ch < 3; ch++) col_win[SPAN-1][ch] = col_sum[ch];
      if (r >= LINES && c >= LINES) begin
        s = 0;
        for (int k = 0; k < SPAN; k++) s += col_win[k][0];
        blurred.red_out = PIX_W'(s / AREA);
        s = 0;
        for (int k = 0; k < SPAN; k++) s += col_win[k][1];
        blurred.green_out = PIX_W'(s / AREA);
        s = 0;
        for (int k = 0; k < SPAN; k++) s += col_win[k][2];
        blurred.blue_out = PIX_W'(s / AREA);
        blurred.centre_row = COORD_W'(r - BLUR_RADIUS);
        blurred.centre_col = COORD_W'(c - BLUR_RADIUS);
        blurred_q.push_back(blurred);
        predicted++;
      end
      line_mem[(r % LINES) * MAX_W + c] = pix;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void flag(string name, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      else if (errors == MAX_REPORTS + 1)
        $display("Further mismatches are counted but not reported.");
    endfunction

    function void check_blurred(out_item_t got);
      out_item_t want;
      if (blurred_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("unexpected result transaction: centre_row %0d, centre_col %0d",
                 got.centre_row, got.centre_col);
        return;
      end
      want = blurred_q.pop_front();
      results++;
      if (got.red_out !== want.red_out)       flag("red_out", want.red_out, got.red_out);
      if (got.green_out !== want.green_out)   flag("green_out", want.green_out, got.green_out);
      if (got.blue_out !== want.blue_out)     flag("blue_out", want.blue_out, got.blue_out);
      if (got.centre_row !== want.centre_row) flag("centre_row", want.centre_row, got.centre_row);
      if (got.centre_col !== want.centre_col) flag("centre_col", want.centre_col, got.centre_col);
    endfunction
  endclass
endpackage

module box_blur_9x9_rgb_unit_tb;
  import bb9_pkg::*;
  import box_blur_tb_pkg::*;

  localparam int RANDOM_ITEMS       = 400;
  localparam int MIN_RANDOM_RESULTS = 60;
  localparam int SETTLE_CYCLES      = 12;
  localparam int LONG_HOLD          = 600;
  localparam int WATCHDOG_LIMIT     = 5000;

  typedef enum int {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_EXTREME, PIX_RAMP} pix_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bb9_in_if  in_if ();
  bb9_out_if out_if ();

  blur_scoreboard sb;
  bit             need_fs;
  bit             long_hold_req;
  int unsigned    geometries;

  box_blur_9x9_rgb_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .RADIUS     (BLUR_RADIUS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t pixel_of(bit fs, pix_t r, pix_t g, pix_t b);
    in_item_t px;
    px.frame_start = fs;
    px.red_in      = r;
    px.green_in    = g;
    px.blue_in     = b;
    return px;
  endfunction

  function automatic in_item_t make_pixel(pix_mode_t mode, int unsigned i);
    case (mode)
      PIX_WHITE:   return pixel_of(1'b0, 8'hFF, 8'hFF, 8'hFF);
      PIX_BLACK:   return pixel_of(1'b0, 8'h00, 8'h00, 8'h00);
      PIX_EXTREME: return pixel_of(1'b0, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                   $urandom_range(0, 1) ? 8'hFF : 8'h00,
                                   $urandom_range(0, 1) ? 8'hFF : 8'h00);
      PIX_RAMP:    return pixel_of(1'b0, PIX_W'(i * 3), PIX_W'(i * 7 + 85), PIX_W'(255 - i));
      default:     return pixel_of(1'b0, PIX_W'($urandom_range(0, 255)),
                                   PIX_W'($urandom_range(0, 255)),
                                   PIX_W'($urandom_range(0, 255)));
    endcase
  endfunction

  // Result receiver: random stalls, stretches without stalls, and one long
  // hold-off on request so that the pipeline fills and stalls its input.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
        run_left      = 0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                    : $urandom_range(0, 6);
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_blurred(out_if.payload);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("No transaction for %0d cycles, giving up.", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_pixel(in_item_t px, int unsigned gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.payload <= px;
    in_if.valid   <= 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.add_pixel(px);
  endtask

  // Stops the sender and waits until the pipeline has emptied.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    int unsigned old_w;
    old_w = blur_scoreboard::eff_dim(sb.width_reg, MAX_W);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_IMAGE_WIDTH, w);
    sb.write_reg(CFG_IMAGE_HEIGHT, h);
    // A wider line would read line-store columns never written in this frame.
    if (blur_scoreboard::eff_dim(w, MAX_W) > old_w) need_fs = 1'b1;
    geometries++;
  endtask

  task automatic send_pixels(int unsigned count, pix_mode_t mode, bit fs_first, bit burst,
                             bit noisy, int hold_at, int pause_at);
    in_item_t px;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      if (i == hold_at) long_hold_req = 1'b1;
      px = make_pixel(mode, i);
      px.frame_start = need_fs || (fs_first && i == 0) ||
                       (noisy && $urandom_range(0, 24) == 0);
      need_fs = 1'b0;
      send_pixel(px, burst ? 0 : pick_gap());
    end
  endtask

  initial begin : stimulus
    int unsigned base_px;
    int unsigned base_res;
    int unsigned frame_no;
    int unsigned sel;
    int unsigned w;
    int unsigned h;
    int unsigned full;
    int unsigned kind;
    pix_mode_t   mode;
    bit          burst;

    sb            = new();
    need_fs       = 1'b0;
    long_hold_req = 1'b0;
    geometries    = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_IMAGE_WIDTH;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: channel extremes and a frame start in mid-line.
    send_pixel(pixel_of(1'b1, 8'hFF, 8'hFF, 8'hFF), 0);
    send_pixel(pixel_of(1'b0, 8'h00, 8'h00, 8'h00), 0);
    send_pixel(pixel_of(1'b0, 8'hFF, 8'h00, 8'h00), 1);
    send_pixel(pixel_of(1'b0, 8'h00, 8'hFF, 8'h00), 0);
    send_pixel(pixel_of(1'b0, 8'h00, 8'h00, 8'hFF), 2);
    send_pixel(pixel_of(1'b1, 8'hAA, 8'h55, 8'hA5), 0);
    send_pixel(pixel_of(1'b0, 8'h55, 8'hAA, 8'h5A), 0);
    // Zero dimensions act as one; a line of eight pixels never gives a result.
    set_geometry(11'd0, 11'd0);
    send_pixels(4, PIX_RANDOM, 1'b0, 1'b0, 1'b0, -1, -1);
    set_geometry(11'd8, 11'd2047);
    send_pixels(20, PIX_EXTREME, 1'b1, 1'b0, 1'b0, -1, -1);

    // Random frames, mostly small and well formed.
    base_px  = sb.pixels;
    base_res = sb.predicted;
    frame_no = 0;
    while (sb.pixels - base_px < RANDOM_ITEMS || sb.predicted - base_res < MIN_RANDOM_RESULTS) begin
      frame_no++;
      sel = $urandom_range(0, 9);
      w = (sel < 7) ? $urandom_range(9, 14) : (sel < 9) ? $urandom_range(15, 24)
                                                         : $urandom_range(0, 8);
      sel = $urandom_range(0, 9);
      h = (sel < 8) ? $urandom_range(9, 12) : (sel < 9) ? $urandom_range(13, 16)
                                                         : $urandom_range(0, 8);
      full  = blur_scoreboard::eff_dim(w, MAX_W) * blur_scoreboard::eff_dim(h, MAX_H);
      mode  = (frame_no == 1) ? PIX_WHITE : (frame_no == 2) ? PIX_BLACK
                                          : pix_mode_t'($urandom_range(0, 4));
      burst = ($urandom_range(0, 3) == 0);
      kind  = (frame_no <= 2) ? 0 : $urandom_range(0, 9);
      case (kind)
        6: begin
          set_geometry(CFG_W'(w), CFG_W'(h));
          send_pixels($urandom_range(1, full), mode, 1'b1, burst, 1'b0, -1, -1);
        end
        7: begin
          // Shrink the geometry in mid-frame and carry on without a frame start.
          set_geometry(CFG_W'(w), CFG_W'(h));
          send_pixels(full / 2 + $urandom_range(0, full / 2), mode, 1'b1, burst, 1'b0, -1, -1);
          set_geometry(CFG_W'($urandom_range(w > 4 ? w - 4 : 0, w)),
                       CFG_W'($urandom_range(h > 3 ? h - 3 : 0, h)));
          send_pixels(full, mode, 1'b0, burst, 1'b0, -1, -1);
        end
        8: begin
          set_geometry(CFG_W'(w), CFG_W'(h));
          send_pixels(full, PIX_RANDOM, 1'b0, burst, 1'b1, -1, -1);
        end
        9: begin
          // Keep going in the current geometry; rows wrap at the frame end.
          full = blur_scoreboard::eff_dim(sb.width_reg, MAX_W) *
                 blur_scoreboard::eff_dim(sb.height_reg, MAX_H);
          send_pixels($urandom_range(1, 2 * full), mode, 1'b0, burst, 1'b0, -1, -1);
        end
        default: begin
          set_geometry(CFG_W'(w), CFG_W'(h));
          send_pixels(full * $urandom_range(1, 2), mode, 1'b1, burst, 1'b0, -1, -1);
        end
      endcase
    end

    // An oversized frame height with a long receiver hold-off once results
    // flow, then a frame where the sender pauses once until all pending results
    // are out, then an oversized line that only advances the column.
    set_geometry(11'd12, 11'd2047);
    send_pixels(12 * 11, PIX_RANDOM, 1'b1, 1'b1, 1'b0, 12 * LINES + LINES, -1);
    set_geometry(11'd10, 11'd12);
    send_pixels(10 * 12, PIX_RANDOM, 1'b1, 1'b0, 1'b0, -1, 110);
    set_geometry(11'd2047, 11'd9);
    send_pixels(40, PIX_EXTREME, 1'b1, 1'b1, 1'b0, -1, -1);

    drain_results();
    $display("Sent %0d pixels over %0d geometries, from 0x0 up to oversized lines and frames.",
             sb.pixels, geometries);
    $display("Checked %0d blurred pixels, %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0 && sb.blurred_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bb9_pkg.sv
hw/rtl/bb9_if.sv
hw/rtl/bb9_position.sv
hw/rtl/bb9_line_store.sv
hw/rtl/bb9_window.sv
hw/rtl/bb9_divide.sv
hw/rtl/box_blur_9x9_rgb_unit.sv
sim/box_blur_9x9_rgb_unit_tb.sv
